[sv/bhpq_pkg.sv]
package bhpq_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] key_value;
        logic [5:0]         entry_index;
    } bhpq_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_data;
        logic [6:0]         entry_count;
    } bhpq_rsp_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_INS_INIT,
        DP_REM_INIT,
        DP_REM_LOAD,
        DP_RD_IDX,
        DP_UP_RD,
        DP_UP_MOVE,
        DP_DN_RD,
        DP_DN_MOVE,
        DP_FINISH
    } bhpq_dp_op_t;

    typedef struct packed {
        bhpq_dp_op_t op;
        logic        respond;
        logic [1:0]  status;
        logic        ret_data;
    } bhpq_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       in_range;
        logic       at_root;
        logic       last_slot;
        logic       up_swap;
        logic       has_left;
        logic       dn_swap;
    } bhpq_stat_t;

endpackage

[sv/bhpq_dp.sv]
module bhpq_dp
    import bhpq_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  bhpq_cmd_t  cmd,
    output bhpq_stat_t stat,
    input  bhpq_req_t  request,
    input  logic       cfg_we,
    input  logic       cfg_data,
    output logic       done,
    output bhpq_rsp_t  result
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = IDX_W + 2;
    localparam int XW    = CW + 6;

    logic [KEY_WIDTH-1:0] mem [CAPACITY];

    bhpq_req_t            req_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic                 order_reg;
    logic [KEY_WIDTH-1:0] rd_a_reg, rd_b_reg;
    logic                 done_reg;
    bhpq_rsp_t            res_reg, res_next;

    logic [IDX_W-1:0]     rd_a_addr, rd_b_addr, wr_addr;
    logic                 wr_en;
    logic [KEY_WIDTH-1:0] wr_data;

    logic [KEY_WIDTH+31:0] key_ext;
    logic [KEY_WIDTH+31:0] data_ext;
    logic [CNT_W+6:0]      cnt_ext;
    logic [XW-1:0]         idx_x, count_xx;
    logic [CW-1:0]         pos_x, count_c, left_c, right_c;
    logic [CNT_W-1:0]      cnt_m1;
    logic [IDX_W-1:0]      pos_m1, parent;
    logic                  has_right, left_up, right_up;

    function automatic logic ranks_above(input logic [KEY_WIDTH-1:0] a,
                                         input logic [KEY_WIDTH-1:0] b,
                                         input logic                 min_mode);
        logic r;
        if (min_mode)
            r = $signed(a) < $signed(b);
        else
            r = $signed(a) > $signed(b);
        return r;
    endfunction

    always_comb
    begin
        key_ext   = {{KEY_WIDTH{req_reg.key_value[31]}}, req_reg.key_value};
        data_ext  = {32'b0, rd_a_reg};
        cnt_ext   = {7'b0, count_reg};
        idx_x     = {{CW{1'b0}}, req_reg.entry_index};
        count_xx  = {{(XW - CNT_W){1'b0}}, count_reg};
        pos_x     = {2'b00, pos_reg};
        count_c   = {{(CW - CNT_W){1'b0}}, count_reg};
        left_c    = {pos_x[CW-2:0], 1'b1};
        right_c   = left_c + 1'b1;
        cnt_m1    = count_reg - 1'b1;
        pos_m1    = pos_reg - 1'b1;
        parent    = pos_m1 >> 1;
        has_right = right_c < count_c;
        left_up   = ranks_above(rd_a_reg, key_reg, order_reg);
        right_up  = has_right && ranks_above(rd_b_reg, left_up ? rd_a_reg : key_reg, order_reg);
    end

    always_comb
    begin
        stat.op        = req_reg.opcode;
        stat.full      = count_reg == CNT_W'(CAPACITY);
        stat.in_range  = idx_x < count_xx;
        stat.at_root   = pos_reg == '0;
        stat.last_slot = pos_x == count_c;
        stat.up_swap   = ranks_above(key_reg, rd_a_reg, order_reg);
        stat.has_left  = left_c < count_c;
        stat.dn_swap   = stat.has_left && (left_up || right_up);
    end

    always_comb
    begin
        count_next = count_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        rd_a_addr  = pos_reg;
        rd_b_addr  = pos_reg;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = key_reg;
        unique case (cmd.op)
            DP_NOP, DP_LOAD:
            begin
            end
            DP_INS_INIT:
            begin
                pos_next   = count_reg[IDX_W-1:0];
                key_next   = key_ext[KEY_WIDTH-1:0];
                count_next = count_reg + 1'b1;
            end
            DP_REM_INIT:
            begin
                rd_a_addr  = cnt_m1[IDX_W-1:0];
                pos_next   = idx_x[IDX_W-1:0];
                count_next = cnt_m1;
            end
            DP_REM_LOAD:
            begin
                key_next = rd_a_reg;
            end
            DP_RD_IDX:
            begin
                rd_a_addr = idx_x[IDX_W-1:0];
            end
            DP_UP_RD:
            begin
                rd_a_addr = parent;
            end
            DP_UP_MOVE:
            begin
                wr_en    = 1'b1;
                wr_data  = rd_a_reg;
                pos_next = parent;
            end
            DP_DN_RD:
            begin
                rd_a_addr = left_c[IDX_W-1:0];
                rd_b_addr = right_c[IDX_W-1:0];
            end
            DP_DN_MOVE:
            begin
                wr_en    = 1'b1;
                wr_data  = right_up ? rd_b_reg : rd_a_reg;
                pos_next = right_up ? right_c[IDX_W-1:0] : left_c[IDX_W-1:0];
            end
            DP_FINISH:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res_next.status      = cmd.status;
        res_next.read_data   = cmd.ret_data ? data_ext[31:0] : 32'sd0;
        res_next.entry_count = cnt_ext[6:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_LOAD)
            req_reg <= request;
        pos_reg <= pos_next;
        key_reg <= key_next;
        if (cmd.respond)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            order_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.respond;
            if (cfg_we)
                order_reg <= cfg_data;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && res_reg.status == ST_FULL |-> count_reg == CNT_W'(CAPACITY))
        else $error("full status with free slots");

    a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_UP_MOVE |-> pos_reg != '0)
        else $error("sift up past root");

endmodule

[sv/bhpq_ctrl.sv]
module bhpq_ctrl
    import bhpq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  bhpq_stat_t stat,
    output bhpq_cmd_t  cmd,
    output logic       busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_REM_LOAD,
        S_READ_WAIT,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   moved_reg, moved_next;
    logic   up_only;

    always_comb
    begin
        state_next   = state_reg;
        moved_next   = moved_reg;
        up_only      = (stat.op == OP_INSERT) || moved_reg;
        cmd.op       = DP_NOP;
        cmd.respond  = 1'b0;
        cmd.status   = ST_DONE;
        cmd.ret_data = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                moved_next = 1'b0;
                priority if (stat.op == OP_INSERT)
                begin
                    if (stat.full)
                    begin
                        cmd.respond = 1'b1;
                        cmd.status  = ST_FULL;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        cmd.op     = DP_INS_INIT;
                        state_next = S_UP_RD;
                    end
                end
                else if (stat.op == OP_REMOVE || stat.op == OP_READ)
                begin
                    if (!stat.in_range)
                    begin
                        cmd.respond = 1'b1;
                        cmd.status  = ST_RANGE;
                        state_next  = S_IDLE;
                    end
                    else if (stat.op == OP_REMOVE)
                    begin
                        cmd.op     = DP_REM_INIT;
                        state_next = S_REM_LOAD;
                    end
                    else
                    begin
                        cmd.op     = DP_RD_IDX;
                        state_next = S_READ_WAIT;
                    end
                end
                else
                begin
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_REM_LOAD:
            begin
                cmd.op = DP_REM_LOAD;
                if (stat.last_slot)
                begin
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                    state_next = S_UP_RD;
            end
            S_READ_WAIT:
            begin
                cmd.respond  = 1'b1;
                cmd.ret_data = 1'b1;
                state_next   = S_IDLE;
            end
            S_UP_RD:
            begin
                if (stat.at_root)
                    state_next = up_only ? S_FINISH : S_DN_RD;
                else
                begin
                    cmd.op     = DP_UP_RD;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (stat.up_swap)
                begin
                    cmd.op     = DP_UP_MOVE;
                    moved_next = 1'b1;
                    state_next = S_UP_RD;
                end
                else
                    state_next = up_only ? S_FINISH : S_DN_RD;
            end
            S_DN_RD:
            begin
                if (stat.has_left)
                begin
                    cmd.op     = DP_DN_RD;
                    state_next = S_DN_CMP;
                end
                else
                    state_next = S_FINISH;
            end
            S_DN_CMP:
            begin
                if (stat.dn_swap)
                begin
                    cmd.op     = DP_DN_MOVE;
                    state_next = S_DN_RD;
                end
                else
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.op      = DP_FINISH;
                cmd.respond = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = state_next != S_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            moved_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            moved_reg <= moved_next;
        end
    end

    assign busy = busy_reg;

    a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg != S_IDLE))
        else $error("busy out of step with state");

    a_respond_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.respond |=> !busy_reg)
        else $error("still busy after response");

endmodule

[sv/binary_heap_priority_queue.sv]
// A rejected item is answered from the decode state, and a read from the state after its indexed read;
// insert and remove walk the heap one level at a time, up or down, until the key settles.
// Each level is one registered memory read, then compare and move in the next cycle.
// Throughput: one transaction at a time; start is taken again in the cycle done is high.
// Reset clears the entry count and order_mode (largest key at root); the key store is not cleared.
// The receiver cannot stall: result is valid only in the single cycle done is high.
module binary_heap_priority_queue
    import bhpq_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  bhpq_req_t request,
    output logic      busy,
    output logic      done,
    output bhpq_rsp_t result,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    bhpq_cmd_t  cmd;
    bhpq_stat_t stat;
    logic       ctrl_busy;

    bhpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (ctrl_busy)
    );

    bhpq_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .request  (request),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .done     (done),
        .result   (result)
    );

    assign busy      = ctrl_busy;
    assign cfg_ready = !ctrl_busy;

endmodule

[sim/binary_heap_priority_queue_tb.sv]
import bhpq_pkg::*;

localparam logic [1:0] OP_SPARE = 2'd3;

class heap_shadow;
    logic signed [31:0] keys [64];
    int unsigned        held;
    bit                 min_root;
    bhpq_rsp_t          outcome_q [$];
    int unsigned        fail_count;

    function bit above(logic signed [31:0] a, logic signed [31:0] b);
        return min_root ? (a < b) : (a > b);
    endfunction

    function void set_order(bit m);
        min_root = m;
    endfunction

    function void swap_keys(int unsigned x, int unsigned y);
        logic signed [31:0] t;
        t       = keys[x];
        keys[x] = keys[y];
        keys[y] = t;
    endfunction

    function int unsigned sift_up(int unsigned start_pos);
        int unsigned pos;
        int unsigned parent;
        pos = start_pos;
        while (pos > 0 && pos < held)
        begin
            parent = (pos - 1) / 2;
            if (!above(keys[pos], keys[parent]))
                break;
            swap_keys(pos, parent);
            pos = parent;
        end
        return pos;
    endfunction

    function void sift_down(int unsigned start_pos);
        int unsigned pos;
        int unsigned best;
        pos = start_pos;
        while (pos < held)
        begin
            best = pos;
            if (2 * pos + 1 < held && above(keys[2 * pos + 1], keys[best]))
                best = 2 * pos + 1;
            if (2 * pos + 2 < held && above(keys[2 * pos + 2], keys[best]))
                best = 2 * pos + 2;
            if (best == pos)
                break;
            swap_keys(pos, best);
            pos = best;
        end
    endfunction

    // one accepted transaction: update the shadow heap and queue its outcome
    function void accept_op(bhpq_req_t r);
        bhpq_rsp_t   want;
        int unsigned idx;
        int unsigned pos;
        want = '0;
        idx  = r.entry_index;
        case (r.opcode)
            OP_INSERT:
            begin
                if (held >= 64)
                    want.status = ST_FULL;
                else
                begin
                    keys[held] = r.key_value;
                    held++;
                    void'(sift_up(held - 1));
                end
            end
            OP_REMOVE:
            begin
                if (idx >= held)
                    want.status = ST_RANGE;
                else
                begin
                    keys[idx] = keys[held - 1];
                    held--;
                    if (idx < held)
                    begin
                        pos = sift_up(idx);
                        if (pos == idx)
                            sift_down(idx);
                    end
                end
            end
            OP_READ:
            begin
                if (idx >= held)
                    want.status = ST_RANGE;
                else
                    want.read_data = keys[idx];
            end
            default:
            begin
            end
        endcase
        want.status      = want.status;
        want.entry_count = 7'(held);
        outcome_q.push_back(want);
    endfunction

    function void match_rsp(bhpq_rsp_t got);
        bhpq_rsp_t want;
        if (outcome_q.size() == 0)
        begin
            fail_count++;
            $error("result with no transaction pending");
            return;
        end
        want = outcome_q.pop_front();
        if (got.status !== want.status)
        begin
            fail_count++;
            $error("status: expected %0d, got %0d", want.status, got.status);
        end
        if (got.read_data !== want.read_data)
        begin
            fail_count++;
            $error("read_data: expected %0d, got %0d", want.read_data, got.read_data);
        end
        if (got.entry_count !== want.entry_count)
        begin
            fail_count++;
            $error("entry_count: expected %0d, got %0d",
                   want.entry_count, got.entry_count);
        end
    endfunction
endclass

module binary_heap_priority_queue_tb;

    localparam int QUIET_LIMIT = 500;
    localparam int CHUNKS      = 6;
    localparam int CHUNK_ITEMS = 317;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      start;
    bhpq_req_t request;
    logic      busy;
    logic      done;
    bhpq_rsp_t result;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;

    heap_shadow  shadow = new();
    int unsigned idle_pct;
    int unsigned quiet_cycles;

    binary_heap_priority_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            shadow.match_rsp(result);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic bhpq_req_t mk(logic [1:0] op, logic signed [31:0] k, logic [5:0] i);
        bhpq_req_t r;
        r.opcode      = op;
        r.key_value   = k;
        r.entry_index = i;
        return r;
    endfunction

    // trend 0 grows the heap, 1 shrinks it, 2 keeps it roughly level
    function automatic bhpq_req_t pick_op(int trend);
        bhpq_req_t   r;
        int unsigned roll;
        int unsigned held;
        held = shadow.held;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            r.key_value = $urandom;
        else if (roll < 8)
            r.key_value = $signed($urandom_range(0, 15)) - 8;
        else if (roll == 8)
            r.key_value = 32'sh7fffffff;
        else
            r.key_value = 32'sh80000000;
        roll = $urandom_range(0, 9);
        if (held > 0 && roll < 7)
            r.entry_index = 6'($urandom_range(0, held - 1));
        else if (roll == 7)
            r.entry_index = 6'(held);
        else
            r.entry_index = 6'($urandom);
        roll = $urandom_range(0, 99);
        case (trend)
            0:       r.opcode = roll < 70 ? OP_INSERT : roll < 85 ? OP_REMOVE :
                                roll < 98 ? OP_READ : OP_SPARE;
            1:       r.opcode = roll < 15 ? OP_INSERT : roll < 75 ? OP_REMOVE :
                                roll < 97 ? OP_READ : OP_SPARE;
            default: r.opcode = roll < 40 ? OP_INSERT : roll < 70 ? OP_REMOVE :
                                roll < 97 ? OP_READ : OP_SPARE;
        endcase
        return r;
    endfunction

    task automatic issue(input bhpq_req_t r);
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        shadow.accept_op(r);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // hold off new transactions until every outcome has been seen
    task automatic settle();
        start <= 1'b0;
        while (shadow.outcome_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_order(input bit m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow.set_order(m);
        @(posedge clk);
    endtask

    initial
    begin
        bhpq_req_t plan [$];
        int        trend;
        int        trend_left;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        request   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;
        idle_pct   = 28;
        trend      = 0;
        trend_left = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_order(1'b0);
        plan = '{mk(OP_READ, 0, 0), mk(OP_REMOVE, 0, 63), mk(OP_SPARE, -1, 63),
                 mk(OP_INSERT, 0, 0), mk(OP_INSERT, 32'sh7fffffff, 0),
                 mk(OP_INSERT, 32'sh80000000, 0), mk(OP_INSERT, -1, 0),
                 mk(OP_INSERT, 5, 0), mk(OP_INSERT, 5, 0), mk(OP_READ, 0, 0),
                 mk(OP_READ, 0, 5), mk(OP_READ, 0, 6), mk(OP_REMOVE, 0, 5),
                 mk(OP_REMOVE, 0, 0), mk(OP_REMOVE, 0, 1), mk(OP_READ, 0, 0)};
        foreach (plan[i])
            issue(plan[i]);
        settle();

        write_order(1'b1);
        plan = '{mk(OP_INSERT, 100, 0), mk(OP_INSERT, -100, 0), mk(OP_READ, 0, 0),
                 mk(OP_REMOVE, 0, 0), mk(OP_READ, 0, 0), mk(OP_REMOVE, 0, 63)};
        foreach (plan[i])
            issue(plan[i]);

        for (int c = 0; c < CHUNKS; c++)
        begin
            settle();
            idle_pct = c < 2 ? 28 : c < 4 ? 51 : 0;
            write_order(c < 4 ? c[0] : 1'($urandom_range(0, 1)));
            for (int n = 0; n < CHUNK_ITEMS; n++)
            begin
                if (trend_left == 0)
                begin
                    trend      = $urandom_range(0, 2);
                    trend_left = $urandom_range(40, 120);
                end
                trend_left--;
                issue(pick_op(trend));
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (shadow.fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
sv/bhpq_pkg.sv
sv/bhpq_dp.sv
sv/bhpq_ctrl.sv
sv/binary_heap_priority_queue.sv
sim/binary_heap_priority_queue_tb.sv
